// ===== hdl/dtr_pkg.sv =====
// Shared types, constants and a helper function for the divider timer.
package dtr_pkg;

    localparam int DIV_W = 16;
    localparam int CNT_W = 8;
    localparam int TICK_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [TICK_W-1:0] RELOAD_DELAY = 3'd4;
    localparam logic [TICK_W-1:0] TICK_MAX = 3'd7;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Divider tap position for each clock_select code.
    localparam logic [3:0] TAP_POS [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WR_DIV = 2'd1,
        CMD_WR_CNT = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMER_ENABLE = 2'd0,
        REG_CLOCK_SELECT = 2'd1,
        REG_RELOAD_VALUE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [DIV_W-1:0] divider_value;
        logic [CNT_W-1:0] counter_value;
    } req_t;

    typedef struct packed {
        logic [7:0]       divider_high;
        logic [CNT_W-1:0] counter_now;
        logic             timer_irq;
    } rsp_t;

    typedef struct packed {
        logic             timer_enable;
        logic [1:0]       clock_select;
        logic [CNT_W-1:0] reload_value;
    } cfg_t;

    function automatic logic tap_level(input logic [DIV_W-1:0] div,
                                       input logic [1:0] sel,
                                       input logic en);
        return div[TAP_POS[sel]] & en;
    endfunction

endpackage

// ===== hdl/dtr_cfg_regs.sv =====
// Configuration register file of the divider timer.
module dtr_cfg_regs
    import dtr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMER_ENABLE: cfg_next.timer_enable = cfg_data[0];
                REG_CLOCK_SELECT: cfg_next.clock_select = cfg_data[1:0];
                REG_RELOAD_VALUE: cfg_next.reload_value = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/dtr_core.sv =====
// Divider and counter state with the single-pass update for one request.
module dtr_core
    import dtr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  req_t req,
    input  cfg_t cfg,
    output rsp_t rsp
);

    logic [DIV_W-1:0]  divider_reg, divider_next;
    logic [CNT_W-1:0]  counter_reg, counter_next;
    logic              pending_reg, pending_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              irq;
    logic              div_load;
    logic              fall;

    always_comb begin
        divider_next = divider_reg;
        counter_next = counter_reg;
        pending_next = pending_reg;
        ticks_next   = ticks_reg;
        irq          = 1'b0;
        div_load     = 1'b0;

        unique case (req.command)
            CMD_TICK: begin
                divider_next = divider_reg + 1'b1;
                div_load     = 1'b1;
            end
            CMD_WR_DIV: begin
                divider_next = req.divider_value;
                div_load     = 1'b1;
            end
            CMD_WR_CNT: counter_next = req.counter_value;
            default: divider_next = divider_reg;
        endcase

        fall = div_load
            && tap_level(divider_reg, cfg.clock_select, cfg.timer_enable)
            && !tap_level(divider_next, cfg.clock_select, cfg.timer_enable);

        if (fall) begin
            if (counter_reg == CNT_MAX) begin
                counter_next = '0;
                pending_next = 1'b1;
                ticks_next   = '0;
            end else begin
                counter_next = counter_reg + 1'b1;
            end
        end

        if (req.command == CMD_TICK && pending_next) begin
            if (ticks_next >= RELOAD_DELAY) begin
                counter_next = cfg.reload_value;
                irq          = 1'b1;
                pending_next = 1'b0;
            end else if (ticks_next < TICK_MAX) begin
                ticks_next = ticks_next + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= '0;
            counter_reg <= '0;
            pending_reg <= 1'b0;
            ticks_reg   <= '0;
        end else if (step) begin
            divider_reg <= divider_next;
            counter_reg <= counter_next;
            pending_reg <= pending_next;
            ticks_reg   <= ticks_next;
        end
    end

    assign rsp.divider_high = divider_next[DIV_W-1:DIV_W-8];
    assign rsp.counter_now  = counter_next;
    assign rsp.timer_irq    = irq;

endmodule

// ===== hdl/divider_timer_with_delayed_reload.sv =====
// Top level of the divider timer with delayed counter reload.
// A request is held in the input register, its result then in the output register.
// Throughput: one request per cycle; the input stalls only while a result waits
// for m_ready.
// Reset: synchronous active-low aresetn clears divider, counter, pending reload,
// configuration registers and both valid flags.
module divider_timer_with_delayed_reload
    import dtr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    req_t in_reg;
    logic in_valid_reg;
    rsp_t out_reg;
    logic out_valid_reg;
    logic advance;
    cfg_t cfg;
    rsp_t rsp;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dtr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (in_reg),
        .cfg     (cfg),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
